// ===== design/mmlcd_pkg.sv =====
`timescale 1ns / 1ps

package mmlcd_pkg;

  // The frame has fourteen positions. Positions 0 to 12 are stored, and position 13 closes the frame.
  localparam int NibbleCount = 13;
  localparam logic [3:0] FramePosLast = 4'd13;

  typedef logic [3:0] nibble_t;
  typedef logic [6:0] seg_code_t;
  typedef logic [2:0] unit_code_t;

  // These are the seven-segment patterns for the numerals 0 through 9.
  localparam seg_code_t SegCodes [10] = '{
    7'h7d, 7'h05, 7'h5b, 7'h1f, 7'h27, 7'h3e, 7'h7e, 7'h15, 7'h7f, 7'h3f
  };

  // This is the overload ("OL") pattern in nibbles 3 through 6.
  localparam logic [2:0] OvlNib3 = 3'h7;
  localparam nibble_t    OvlNib4 = 4'hd;
  localparam logic [2:0] OvlNib5 = 3'h6;
  localparam nibble_t    OvlNib6 = 4'h8;

  localparam unit_code_t UnitFarad   = 3'd0;
  localparam unit_code_t UnitOhm     = 3'd1;
  localparam unit_code_t UnitAmp     = 3'd2;
  localparam unit_code_t UnitHertz   = 3'd3;
  localparam unit_code_t UnitVolt    = 3'd4;
  localparam unit_code_t UnitPercent = 3'd5;
  localparam unit_code_t UnitCelsius = 3'd6;
  localparam unit_code_t UnitUnknown = 3'd7;

  typedef struct packed {
    logic        hit;
    logic [3:0]  numeral;
  } seg_match_t;

  typedef struct packed {
    logic signed [14:0] reading;
    logic [1:0]         fraction_digits;
    logic               overload;
    logic               digit_error;
    logic               ac_mode;
    unit_code_t         unit_code;
  } result_t;

  // The function compares the code against all ten patterns in parallel.
  // A code that matches no pattern returns hit low.
  function automatic seg_match_t seg_lookup(input seg_code_t code);
    seg_match_t m;
    m.hit     = 1'b0;
    m.numeral = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (SegCodes[i] == code) begin
        m.hit     = 1'b1;
        m.numeral = 4'(i);
      end
    end
    return m;
  endfunction

endpackage

// ===== design/mmlcd_decode.sv =====
`timescale 1ns / 1ps

module mmlcd_decode (
  input  mmlcd_pkg::nibble_t frame_nibbles [mmlcd_pkg::NibbleCount],
  input  mmlcd_pkg::nibble_t last_nibble,
  output mmlcd_pkg::result_t result
);

  mmlcd_pkg::seg_match_t match [4];
  logic [13:0]           magnitude;
  logic                  any_miss;
  logic                  ovl_hit;
  logic [1:0]            frac;
  logic signed [14:0]    signed_mag;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      match[k] = mmlcd_pkg::seg_lookup({frame_nibbles[1 + 2 * k][2:0],
                                        frame_nibbles[2 + 2 * k]});
    end
    any_miss = !(match[0].hit && match[1].hit && match[2].hit && match[3].hit);

    magnitude = 14'(match[0].numeral) * 14'd1000 + 14'(match[1].numeral) * 14'd100
              + 14'(match[2].numeral) * 14'd10 + 14'(match[3].numeral);

    ovl_hit = (frame_nibbles[3][2:0] == mmlcd_pkg::OvlNib3) &&
              (frame_nibbles[4] == mmlcd_pkg::OvlNib4) &&
              (frame_nibbles[5][2:0] == mmlcd_pkg::OvlNib5) &&
              (frame_nibbles[6] == mmlcd_pkg::OvlNib6);

    // When several decimal points are lit, the first one lit takes effect.
    if (frame_nibbles[3][3]) begin
      frac = 2'd3;
    end else if (frame_nibbles[5][3]) begin
      frac = 2'd2;
    end else if (frame_nibbles[7][3]) begin
      frac = 2'd1;
    end else begin
      frac = 2'd0;
    end

    signed_mag = $signed({1'b0, magnitude});

    result = '0;
    if (ovl_hit) begin
      result.overload = 1'b1;
      result.reading  = -15'sd1;
    end else if (any_miss) begin
      result.digit_error = 1'b1;
    end else begin
      result.fraction_digits = frac;
      result.reading         = frame_nibbles[1][3] ? -signed_mag : signed_mag;
    end

    result.ac_mode = frame_nibbles[0][3];

    if (frame_nibbles[11][3]) begin
      result.unit_code = mmlcd_pkg::UnitFarad;
    end else if (frame_nibbles[11][2]) begin
      result.unit_code = mmlcd_pkg::UnitOhm;
    end else if (frame_nibbles[12][3]) begin
      result.unit_code = mmlcd_pkg::UnitAmp;
    end else if (frame_nibbles[12][1]) begin
      result.unit_code = mmlcd_pkg::UnitHertz;
    end else if (frame_nibbles[12][2]) begin
      result.unit_code = mmlcd_pkg::UnitVolt;
    end else if (frame_nibbles[10][2]) begin
      result.unit_code = mmlcd_pkg::UnitPercent;
    end else if (last_nibble[0]) begin
      result.unit_code = mmlcd_pkg::UnitCelsius;
    end else begin
      result.unit_code = mmlcd_pkg::UnitUnknown;
    end
  end

endmodule

// ===== design/multimeter_lcd_frame_decoder_top.sv =====
`timescale 1ns / 1ps

// This block decodes the 14-byte LCD frame of a multimeter. Each input word carries one
// frame byte in in_tdata and that byte's position (0 to 13) in in_tuser. Only the low
// nibble of each byte is used. Positions 0 to 12 go into a 13-entry nibble register file.
// These words produce no result. A word at position 13 completes the frame and produces
// one result word. That word carries the signed four-digit reading, the number of
// fraction digits, the overload flag (the reading is then -1), a digit error flag for a
// segment pattern that matches no numeral (the reading and the fraction digits are then
// 0), the AC flag, and the unit code. Positions 14 and 15 are ignored.
//
// The block accepts one word per clock while in_tready is high. The decode is a single
// combinational pass from the nibble registers and the incoming byte into the result
// register, or into the skid register when the output is stalled. The output has a result
// register and a one-entry skid register. in_tready drops only while the skid register
// holds a result, which happens only after a result has waited on a stalled output
// during a second frame end.
//
// Fields read from a position that has not been written since reset are undefined.
module multimeter_lcd_frame_decoder_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic [3:0]  in_tuser,   // [3:0] byte_position

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [14:0] reading, [16:15] fraction_digits,
                                  // [17] overload, [18] digit_error, [19] ac_mode,
                                  // [22:20] unit_code, [23] zero
);

  mmlcd_pkg::nibble_t nib_r [mmlcd_pkg::NibbleCount];
  mmlcd_pkg::result_t decoded;
  mmlcd_pkg::result_t out_data_r, out_data_nxt;
  mmlcd_pkg::result_t skid_data_r, skid_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic               in_fire;
  logic               store_fire;
  logic               result_fire;

  assign in_tready   = !skid_valid_r;
  assign in_fire     = in_tvalid && in_tready;
  assign store_fire  = in_fire && (in_tuser < 4'(mmlcd_pkg::NibbleCount));
  assign result_fire = in_fire && (in_tuser == mmlcd_pkg::FramePosLast);

  // The nibble register file has no reset. Each entry holds the last nibble written at
  // its position.
  always_ff @(posedge clk) begin
    if (store_fire) begin
      nib_r[in_tuser] <= in_tdata[3:0];
    end
  end

  // The closing byte's own nibble goes into the decode directly, because bit 0 of that
  // nibble selects Celsius.
  mmlcd_decode u_decode (
    .frame_nibbles (nib_r),
    .last_nibble   (in_tdata[3:0]),
    .result        (decoded)
  );

  // The output has two stages. The result register feeds the port. The skid register
  // catches a result that arrives while the result register is full and stalled.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (result_fire) begin
        out_data_nxt = decoded;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r) begin
      if (result_fire) begin
        out_data_nxt  = decoded;
        out_valid_nxt = 1'b1;
      end
    end else begin
      if (result_fire) begin
        skid_data_nxt  = decoded;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.unit_code, out_data_r.ac_mode,
                       out_data_r.digit_error, out_data_r.overload,
                       out_data_r.fraction_digits, out_data_r.reading};

`ifndef SYNTHESIS
  // The skid register fills only while the result register is full.
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  // A frame end that meets a full, stalled output must be caught by the skid register.
  a_stall_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (result_fire && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result lost on a stalled output");

  // An overload result has a reading of -1 and no digit error.
  a_overload_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.overload) |->
      (out_data_r.reading == -15'sd1 && !out_data_r.digit_error &&
       out_data_r.fraction_digits == 2'd0))
    else $error("overload result is malformed");

  // A digit error result has a zero reading and no fraction digits.
  a_digit_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.digit_error) |->
      (out_data_r.reading == 15'sd0 && out_data_r.fraction_digits == 2'd0))
    else $error("digit error result carries a reading");
`endif

endmodule

// ===== verif/multimeter_lcd_frame_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module multimeter_lcd_frame_decoder_top_tb;

  localparam int ClockPeriod = 4;
  localparam int ResetCycles = 11;
  localparam int TargetWords = 500;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;

  // Tracks the nibble register file of the decoder and holds the readings that
  // closed frames are due to produce, oldest first.
  class reading_scoreboard;
    mmlcd_pkg::nibble_t nibbles [mmlcd_pkg::NibbleCount];
    mmlcd_pkg::result_t pending_readings [$];
    int unsigned        failures;

    function new();
      failures = 0;
      foreach (nibbles[i]) nibbles[i] = '0;
    endfunction

    // Seven-segment patterns of the numerals, as the meter drives its LCD.
    static function mmlcd_pkg::seg_code_t pattern_of(int numeral);
      case (numeral)
        0: return 7'h7d;
        1: return 7'h05;
        2: return 7'h5b;
        3: return 7'h1f;
        4: return 7'h27;
        5: return 7'h3e;
        6: return 7'h7e;
        7: return 7'h15;
        8: return 7'h7f;
        default: return 7'h3f;
      endcase
    endfunction

    static function int numeral_of(mmlcd_pkg::seg_code_t code);
      for (int d = 0; d < 10; d++) begin
        if (pattern_of(d) == code) return d;
      end
      return -1;
    endfunction

    // Decodes the stored frame together with the nibble of the closing byte.
    function mmlcd_pkg::result_t decode_frame(mmlcd_pkg::nibble_t closing_nib);
      mmlcd_pkg::result_t   r;
      mmlcd_pkg::seg_code_t code;
      int                   numeral;
      int                   magnitude;
      logic                 bad_digit;
      r = '0;
      magnitude = 0;
      bad_digit = 1'b0;
      if (nibbles[3][2:0] == mmlcd_pkg::OvlNib3 && nibbles[4] == mmlcd_pkg::OvlNib4 &&
          nibbles[5][2:0] == mmlcd_pkg::OvlNib5 && nibbles[6] == mmlcd_pkg::OvlNib6) begin
        r.overload = 1'b1;
        r.reading  = -15'sd1;
      end else begin
        for (int k = 0; k < 4; k++) begin
          code    = {nibbles[1 + 2 * k][2:0], nibbles[2 + 2 * k]};
          numeral = numeral_of(code);
          if (numeral < 0) bad_digit = 1'b1;
          else magnitude = magnitude * 10 + numeral;
        end
        if (bad_digit) begin
          r.digit_error = 1'b1;
        end else begin
          // The first decimal point lit from the left decides the scale.
          if (nibbles[3][3]) r.fraction_digits = 2'd3;
          else if (nibbles[5][3]) r.fraction_digits = 2'd2;
          else if (nibbles[7][3]) r.fraction_digits = 2'd1;
          r.reading = nibbles[1][3] ? 15'(-magnitude) : 15'(magnitude);
        end
      end
      r.ac_mode = nibbles[0][3];
      if (nibbles[11][3]) r.unit_code = mmlcd_pkg::UnitFarad;
      else if (nibbles[11][2]) r.unit_code = mmlcd_pkg::UnitOhm;
      else if (nibbles[12][3]) r.unit_code = mmlcd_pkg::UnitAmp;
      else if (nibbles[12][1]) r.unit_code = mmlcd_pkg::UnitHertz;
      else if (nibbles[12][2]) r.unit_code = mmlcd_pkg::UnitVolt;
      else if (nibbles[10][2]) r.unit_code = mmlcd_pkg::UnitPercent;
      else if (closing_nib[0]) r.unit_code = mmlcd_pkg::UnitCelsius;
      else r.unit_code = mmlcd_pkg::UnitUnknown;
      return r;
    endfunction

    function void note_byte(logic [7:0] frame_byte, logic [3:0] position);
      if (position < mmlcd_pkg::FramePosLast) nibbles[position] = frame_byte[3:0];
      else if (position == mmlcd_pkg::FramePosLast)
        pending_readings.push_back(decode_frame(frame_byte[3:0]));
    endfunction

    function void compare_field(string name, logic [14:0] want, logic [14:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [23:0] word);
      mmlcd_pkg::result_t want;
      if (pending_readings.size() == 0) begin
        $display("%0t: result word %h arrived with no reading expected", $time, word);
        failures++;
        return;
      end
      want = pending_readings.pop_front();
      compare_field("reading", want.reading, word[14:0]);
      compare_field("fraction_digits", 15'(want.fraction_digits), 15'(word[16:15]));
      compare_field("overload", 15'(want.overload), 15'(word[17]));
      compare_field("digit_error", 15'(want.digit_error), 15'(word[18]));
      compare_field("ac_mode", 15'(want.ac_mode), 15'(word[19]));
      compare_field("unit_code", 15'(want.unit_code), 15'(word[22:20]));
      compare_field("pad bit", 15'd0, 15'(word[23]));
    endfunction

    function int unsigned pending();
      return pending_readings.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] frame_byte
  logic [3:0]  in_tuser;    // [3:0] byte_position
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [14:0] reading, [16:15] fraction_digits, [17] overload,
                            // [18] digit_error, [19] ac_mode, [22:20] unit_code, [23] zero

  reading_scoreboard board;
  int unsigned       words_sent;
  int unsigned       cycle_count;

  multimeter_lcd_frame_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(ClockPeriod / 2) clk = ~clk;
  end

  // The run is cut off if it ever takes far longer than the slowest legal run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Both channels are observed at the rising edge. Values read here are the ones
  // that were stable before the edge, so no ordering within the time step matters.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
    end
  end

  function automatic bit one_in(int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  // Most gaps are absent or short; a few are long enough to back the block up.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The receiver alternates runs of readiness with stalls. Some runs are long,
  // which gives stretches where the output never stalls.
  initial begin
    int run_len;
    int stall_len;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      run_len = one_in(6) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run_len) begin
        @(negedge clk);
        out_tready <= 1'b1;
      end
      stall_len = pick_gap();
      repeat (stall_len) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // Valid is left high so a following word goes out back to back.
  task automatic send_word(logic [7:0] frame_byte, logic [3:0] position);
    in_tvalid <= 1'b1;
    in_tdata  <= frame_byte;
    in_tuser  <= position;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (position <= mmlcd_pkg::FramePosLast) words_sent++;
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Holds the sender off until every reading already owed has come out.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Builds one well-formed frame with random content and sends it. Most frames go
  // in order; some are shuffled, some only refresh a few positions, and a few are
  // abandoned before the closing byte. Ignored positions 14 and 15 are sprinkled
  // in as noise.
  task automatic send_random_frame();
    mmlcd_pkg::nibble_t   nib [14];
    mmlcd_pkg::seg_code_t code;
    int                   digit_mode;
    int                   bad_slot;
    int                   order [$];
    int                   style;
    int                   j;
    int                   tmp;
    bit                   quiet;
    digit_mode = $urandom_range(0, 19);
    bad_slot   = $urandom_range(0, 3);
    nib[0] = 4'($urandom);
    for (int k = 0; k < 4; k++) begin
      if (digit_mode == 0) code = reading_scoreboard::pattern_of(0);
      else if (digit_mode == 1) code = reading_scoreboard::pattern_of(9);
      else code = reading_scoreboard::pattern_of($urandom_range(0, 9));
      if ((digit_mode == 3 || digit_mode == 4) && k == bad_slot) code = 7'($urandom);
      nib[1 + 2 * k] = {one_in(3), code[6:4]};
      nib[2 + 2 * k] = code[3:0];
    end
    // Overload keeps the decimal point bits of positions 3 and 5 random.
    if (digit_mode == 2) begin
      nib[3][2:0] = mmlcd_pkg::OvlNib3;
      nib[4]      = mmlcd_pkg::OvlNib4;
      nib[5][2:0] = mmlcd_pkg::OvlNib5;
      nib[6]      = mmlcd_pkg::OvlNib6;
    end
    nib[9]  = 4'($urandom);
    nib[10] = {1'($urandom), one_in(4), 2'($urandom)};
    nib[11] = {one_in(4), one_in(4), 2'($urandom)};
    nib[12] = {one_in(4), one_in(4), one_in(4), 1'($urandom)};
    nib[13] = 4'($urandom);

    style = $urandom_range(0, 19);
    for (int p = 0; p < mmlcd_pkg::NibbleCount; p++) begin
      if (style < 17 || one_in(3)) order.push_back(p);
    end
    if (style >= 14 && style < 17) begin
      for (int i = order.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    if (!one_in(20)) order.push_back(int'(mmlcd_pkg::FramePosLast));

    quiet = one_in(4);
    foreach (order[i]) begin
      if (one_in(12)) begin
        send_word(8'($urandom), 4'($urandom_range(14, 15)));
        idle_gap(quiet ? 0 : pick_gap());
      end
      send_word({4'($urandom), nib[order[i]]}, 4'(order[i]));
      idle_gap(quiet ? 0 : pick_gap());
    end
  endtask

  initial begin
    logic [7:0] first_frame [14];
    // The first frame fills every stored position: all nines with the minus sign,
    // every decimal point lit, AC, and farad. Upper nibbles swing between 0 and F.
    first_frame = '{
      8'hff, 8'hfb, 8'h0f, 8'hfb, 8'h0f, 8'hfb, 8'h0f,
      8'hfb, 8'h0f, 8'hf0, 8'h00, 8'hff, 8'h0f, 8'hff
    };
    board      = new();
    words_sent = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (first_frame[i]) send_word(first_frame[i], 4'(i));
    // Positions 14 and 15 must be ignored.
    send_word(8'h00, 4'd14);
    send_word(8'hff, 4'd15);
    // Overload pattern in positions 3 to 6.
    send_word(8'h07, 4'd3);
    send_word(8'hfd, 4'd4);
    send_word(8'h06, 4'd5);
    send_word(8'h08, 4'd6);
    send_word(8'h00, mmlcd_pkg::FramePosLast);
    // Breaking position 4 ends the overload and leaves a digit with no numeral.
    send_word(8'hf0, 4'd4);
    send_word(8'hf1, mmlcd_pkg::FramePosLast);
    wait_for_drain();

    while (words_sent < TargetWords) begin
      send_random_frame();
      if (one_in(15)) wait_for_drain();
    end

    // All stimulus is in; let every owed reading arrive, then watch a little longer
    // for anything unexpected.
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== multimeter_lcd_frame_decoder_top.f =====
design/mmlcd_pkg.sv
design/mmlcd_decode.sv
design/multimeter_lcd_frame_decoder_top.sv
verif/multimeter_lcd_frame_decoder_top_tb.sv
